[hw/rtl/dq_pkg.sv]
`timescale 1ns / 1ps

package dq_pkg;

    // Default ring depth
    localparam int DEPTH_DEF = 64;

    localparam int WORD_W = 32;
    localparam int OCC_W  = 7;

    // Operation codes
    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_BACK   = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_PEEK_BACK  = 3'd4;
    localparam logic [2:0] OP_PEEK_FRONT = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [WORD_W-1:0] push_value;
    } dq_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
    } dq_out_t;

endpackage

[hw/rtl/dq_ram.sv]
`timescale 1ns / 1ps

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/double_ended_queue.sv]
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit words held in a ring of DEPTH entries in
// one RAM (one write port, one registered read port). Each accepted word names
// one operation (push/pop/peek at back or front) and yields exactly one result
// word carrying the word read (zero for pushes and errors), a status (ok,
// empty, full) and the occupancy after the operation. Push on a full queue and
// pop/peek on an empty queue change nothing and are flagged. Opcodes 6 and 7
// are no-ops with status ok. Sustained rate is one operation per clock while
// the result side keeps up; a result is registered in the RAM read port and
// stage 2, then in the output register. Pointer and count updates happen at
// accept time, so a read that follows a write to the same slot always sees
// the new word. Occupancy is the count modulo 128.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  dq_in_t  s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output dq_out_t m_data
);

    localparam int IW = $clog2(DEPTH);       // slot index width
    localparam int CW = $clog2(DEPTH + 1);   // count width, holds DEPTH itself
    localparam int SW = CW + 1;              // head + count sum width

    localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_SUM = SW'(DEPTH);

    // Ring state
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;

    // Stage 2: waiting on RAM read data
    logic             p_valid_reg;
    logic             p_read_reg;
    logic [1:0]       p_status_reg;
    logic [OCC_W-1:0] p_occ_reg;
    logic             p_read_next;
    logic [1:0]       p_status_next;

    // Output register
    logic    m_valid_reg;
    dq_out_t m_data_reg;

    // RAM ports
    logic              ram_we;
    logic              ram_re;
    logic [IW-1:0]     ram_waddr;
    logic [IW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic          accept;
    logic          advance;
    logic          is_empty;
    logic          is_full;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] back_sum;
    logic [IW-1:0] tail_idx;
    logic [IW-1:0] back_idx;
    logic [IW-1:0] head_dec;
    logic [IW-1:0] head_inc;
    logic [31:0]   occ_ext;

    // Stage 2 moves on when the output register is free or being drained;
    // a new op may enter when stage 2 is empty or moves on, so RAM read data is never overwritten.
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !p_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == FULL_CNT);

    // Slot arithmetic; every sum stays below 2*DEPTH (back_sum only when not empty) so one subtract wraps it.
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign back_sum = tail_sum - SW'(1);
    assign tail_idx = (tail_sum >= DEPTH_SUM) ? IW'(tail_sum - DEPTH_SUM) : IW'(tail_sum);
    assign back_idx = (back_sum >= DEPTH_SUM) ? IW'(back_sum - DEPTH_SUM) : IW'(back_sum);
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - IW'(1);
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + IW'(1);

    // Operation decode: pointer update, RAM access and status
    always_comb begin
        head_next     = head_reg;
        count_next    = count_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = tail_idx;
        ram_raddr     = back_idx;
        p_read_next   = 1'b0;
        p_status_next = ST_OK;
        unique case (s_data.opcode) inside
            OP_PUSH_BACK: begin
                if (is_full) begin
                    p_status_next = ST_FULL;
                end else begin
                    ram_we     = accept;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    p_status_next = ST_FULL;
                end else begin
                    ram_we     = accept;
                    ram_waddr  = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
                if (is_empty) begin
                    p_status_next = ST_EMPTY;
                end else begin
                    ram_re      = accept;
                    p_read_next = 1'b1;
                    if (s_data.opcode == OP_POP_BACK) begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (is_empty) begin
                    p_status_next = ST_EMPTY;
                end else begin
                    ram_re      = accept;
                    ram_raddr   = head_reg;
                    p_read_next = 1'b1;
                    if (s_data.opcode == OP_POP_FRONT) begin
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            default: begin
                // unused opcodes: no-op
            end
        endcase
    end

    // occupancy is reported modulo 2^7
    assign occ_ext = 32'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
            if (s_ready) begin
                p_valid_reg <= accept;
            end
            if (advance) begin
                m_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_read_reg   <= p_read_next;
            p_status_reg <= p_status_next;
            p_occ_reg    <= occ_ext[OCC_W-1:0];
        end
        if (advance && p_valid_reg) begin
            m_data_reg.read_value <= p_read_reg ? $signed(ram_rdata) : '0;
            m_data_reg.status     <= p_status_reg;
            m_data_reg.occupancy  <= p_occ_reg;
        end
    end

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_data.push_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[tb/double_ended_queue_test.sv]
`timescale 1ns / 1ps

module double_ended_queue_test;
    import dq_pkg::*;

    // Opcodes with no operation behind them: the block answers ok and changes nothing
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam int RING_DEPTH     = DEPTH_DEF;
    localparam int RANDOM_WORDS   = 1000;
    localparam int LONG_HOLD      = 400;   // receiver back-pressure stretch, in cycles
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int MAX_PRINTED    = 40;

    // Shadow copy of the deque: the ring, the front pointer and the count, plus
    // the queue of results still owed by the block, oldest first.
    class deque_shadow;
        logic [WORD_W-1:0] ring [RING_DEPTH];
        int unsigned       head;
        int unsigned       count;
        dq_out_t           owed_results [$];
        int                errors;

        function new();
            head   = 0;
            count  = 0;
            errors = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Apply one accepted operation and queue the result it must produce.
        function void note_op(dq_in_t w);
            dq_out_t r;
            r.read_value = '0;
            r.status     = ST_OK;
            case (w.opcode)
                OP_PUSH_BACK, OP_PUSH_FRONT: begin
                    if (count >= RING_DEPTH) begin
                        r.status = ST_FULL;
                    end else if (w.opcode == OP_PUSH_BACK) begin
                        ring[(head + count) % RING_DEPTH] = w.push_value;
                        count++;
                    end else begin
                        head = (head + RING_DEPTH - 1) % RING_DEPTH;
                        ring[head] = w.push_value;
                        count++;
                    end
                end
                OP_POP_BACK, OP_PEEK_BACK: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.read_value = ring[(head + count - 1) % RING_DEPTH];
                        if (w.opcode == OP_POP_BACK)
                            count--;
                    end
                end
                OP_POP_FRONT, OP_PEEK_FRONT: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.read_value = ring[head];
                        if (w.opcode == OP_POP_FRONT) begin
                            head = (head + 1) % RING_DEPTH;
                            count--;
                        end
                    end
                end
                default: ;
            endcase
            r.occupancy = OCC_W'(count);
            owed_results.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_word(dq_out_t got);
            dq_out_t want;
            if (owed_results.size() == 0) begin
                report($sformatf("result with none owed: value %0d status %0d occ %0d",
                                 got.read_value, got.status, got.occupancy));
                return;
            end
            want = owed_results.pop_front();
            if (got.read_value !== want.read_value)
                report($sformatf("read_value %0d, want %0d", got.read_value, want.read_value));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.occupancy !== want.occupancy)
                report($sformatf("occupancy %0d, want %0d", got.occupancy, want.occupancy));
        endtask
    endclass

    logic    aclk = 1'b0;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    dq_in_t  s_data;
    logic    m_valid;
    logic    m_ready;
    dq_out_t m_data;

    deque_shadow shadow = new();

    // Traffic shaping, set per phase by the stimulus process
    bit tx_burst = 1'b0;    // sender never idles
    bit rx_burst = 1'b0;    // receiver takes no random stalls
    bit hold_req = 1'b0;    // ask the receiver for one long stall
    int idle_cycles = 0;

    double_ended_queue DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Word extremes show up often so both ends of the signed range get stored
    function automatic logic [WORD_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // push_pct steers the fill level: high fills the ring up to full, low
    // drains it and keeps hitting the empty case.
    function automatic logic [2:0] rand_op(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return $urandom_range(0, 1) ? OP_RSVD7 : OP_RSVD6;
        if (r < 3 + push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        case ($urandom_range(0, 5))
            0: return OP_PEEK_BACK;
            1: return OP_PEEK_FRONT;
            2, 3: return OP_POP_BACK;
            default: return OP_POP_FRONT;
        endcase
    endfunction

    // Offer one word and hold it until taken. Valid stays up into the next
    // word when no gap follows, so it is never dropped and raised in one step.
    task automatic send_op(input logic [2:0] op, input logic [WORD_W-1:0] val);
        int gap;
        s_valid <= 1'b1;
        s_data  <= '{opcode: op, push_value: val};
        do @(posedge aclk); while (!s_ready);
        gap = tx_burst ? 0 : rand_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // One edge first, so the word taken at the current edge is already noted
    task automatic wait_all_results();
        @(posedge aclk);
        while (shadow.pending() != 0)
            @(posedge aclk);
    endtask

    // Both channels are sampled here, at the edge, before any NBA update
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                shadow.note_op(s_data);
            if (m_valid && m_ready)
                shadow.check_word(m_data);
        end
    end

    // Hang detection: too long with nothing moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL double_ended_queue");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stalls, none in burst phases, one long hold on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!rx_burst)
                    stall_left = rand_gap();
            end
        end
    end

    initial begin
        int sent;
        int phase;
        int len;
        int push_pct;

        s_valid <= 1'b0;
        s_data  <= '0;
        aresetn <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every read on an empty queue, the unused opcodes, word
        // extremes at both ends, front push wrapping below slot zero, and
        // popping the last word.
        send_op(OP_POP_BACK,   32'h1234_5678);
        send_op(OP_POP_FRONT,  '1);
        send_op(OP_PEEK_BACK,  '0);
        send_op(OP_PEEK_FRONT, 32'h8000_0000);
        send_op(OP_RSVD6,      32'h7fff_ffff);
        send_op(OP_RSVD7,      '1);
        send_op(OP_PUSH_BACK,  32'h7fff_ffff);
        send_op(OP_PUSH_FRONT, 32'h8000_0000);
        send_op(OP_PUSH_BACK,  '0);
        send_op(OP_PUSH_FRONT, '1);
        send_op(OP_PEEK_BACK,  '0);
        send_op(OP_PEEK_FRONT, '0);
        send_op(OP_POP_FRONT,  '0);
        send_op(OP_POP_BACK,   '0);
        send_op(OP_PEEK_FRONT, '0);
        send_op(OP_POP_BACK,   '0);
        send_op(OP_POP_FRONT,  '0);
        send_op(OP_POP_FRONT,  '0);
        send_op(OP_PUSH_FRONT, 32'h5555_5555);
        send_op(OP_PUSH_BACK,  32'haaaa_aaaa);
        send_op(OP_POP_BACK,   '0);
        send_op(OP_POP_BACK,   '0);
        send_op(OP_PEEK_BACK,  '0);

        // Random phases: fill, drain or mixed, with burst or idle traffic
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            len = $urandom_range(40, 120);
            case ($urandom_range(0, 3))
                0: push_pct = 85;
                1: push_pct = 12;
                default: push_pct = 45;
            endcase
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // Back-pressure: receiver stalls while words keep coming
                push_pct = 60;
                tx_burst = 1'b1;
                len      = 200;
                hold_req = 1'b1;
            end
            if (phase % 4 == 3) begin
                // Quiet point: sender waits for every owed result
                s_valid <= 1'b0;
                wait_all_results();
            end
            repeat (len) begin
                send_op(rand_op(push_pct), rand_value());
                sent++;
            end
            phase++;
        end
        s_valid <= 1'b0;

        wait_all_results();
        repeat (8) @(posedge aclk);
        if (shadow.pending() != 0)
            shadow.report($sformatf("%0d results never arrived", shadow.pending()));

        if (shadow.errors == 0)
            $display("PASS double_ended_queue");
        else
            $display("FAIL double_ended_queue");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/dq_pkg.sv
hw/rtl/dq_ram.sv
hw/rtl/double_ended_queue.sv
tb/double_ended_queue_test.sv
